[src/dshu_pkg.sv]
// ----------------------------------------------------------------------------
// dshu_pkg
// Shared constants and command types for the dual-seed hash UUID block.
// ----------------------------------------------------------------------------
`default_nettype none

package dshu_pkg;

  localparam int unsigned LaneW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NLanes = 2;
  localparam int unsigned AddrW  = 4;

  // FNV prime is 2^40 + 0x1b3: a shift plus a narrow multiply
  localparam int unsigned  FnvShift = 40;
  localparam logic [8:0]   FnvLow   = 9'h1b3;

  localparam logic [LaneW-1:0] FmixMulA   = 64'hff51afd7ed558ccd;
  localparam logic [LaneW-1:0] FmixMulB   = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned      FmixShift  = 33;

  localparam logic [LaneW-1:0] UpperSeedReset = 64'd14695981039346656037;
  localparam logic [LaneW-1:0] LowerSeedReset = 64'd7809847782465536322;

  // Lane indexes
  localparam int unsigned LaneUpper = 0;
  localparam int unsigned LaneLower = 1;

  // Register indexes (address bit 3 selects the register)
  localparam logic RegUpperSeed = 1'b0;
  localparam logic RegLowerSeed = 1'b1;

  // UUID marks
  localparam logic [3:0] VersionNibble = 4'b1000;
  localparam logic [1:0] VariantBits   = 2'b10;

  // Multiply phases of the partial-product sequence
  typedef enum logic [1:0] {
    PH_LOLO = 2'd0,
    PH_LOHI = 2'd1,
    PH_HILO = 2'd2,
    PH_SUM  = 2'd3
  } mul_phase_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       fnv_en;     // fold accepted byte into both lanes
    logic       fin_load;   // start finalizer, reload lanes from seeds
    logic       mul_en;     // run one multiply phase
    mul_phase_e phase;
    logic       const_sel;  // 0: first fmix constant, 1: second
    logic       xs_en;      // xor-shift the product back into the work value
    logic       out_load;   // capture the UUID into the output register
  } dshu_cmd_t;

endpackage : dshu_pkg

`default_nettype wire

[src/dshu_ctrl.sv]
// ----------------------------------------------------------------------------
// dshu_ctrl
// Sequencer for the hash block: accepts bytes, steps the finalizer through
// two multiply rounds and hands the UUID to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dshu_ctrl
  import dshu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      final_byte_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output dshu_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_MUL,
    S_XS,
    S_OUT
  } state_e;

  state_e     state_q, state_d;
  mul_phase_e phase_q, phase_d;
  logic       round_q, round_d;
  logic       in_stall_q;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    round_d        = round_q;
    cmd_o          = '0;
    cmd_o.phase    = phase_q;
    cmd_o.const_sel = round_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.fnv_en = 1'b1;
          if (final_byte_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.fin_load = 1'b1;
        phase_d        = PH_LOLO;
        round_d        = 1'b0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (phase_q == PH_SUM) begin
          state_d = S_XS;
        end else begin
          phase_d = mul_phase_e'(phase_q + 2'd1);
        end
      end
      S_XS: begin
        cmd_o.xs_en = 1'b1;
        phase_d     = PH_LOLO;
        if (round_q) begin
          state_d = S_OUT;
        end else begin
          round_d = 1'b1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_LOLO;
      round_q     <= 1'b0;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      round_q     <= round_d;
      in_stall_q  <= (state_d != S_IDLE);
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

endmodule : dshu_ctrl

`default_nettype wire

[src/dshu_dp.sv]
// ----------------------------------------------------------------------------
// dshu_dp
// Datapath: seed registers, two FNV-1a lanes, a fmix64 unit per lane built
// on one 32x32 multiplier, and the UUID output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dshu_dp
  import dshu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dshu_cmd_t          cmd_i,
  input  logic [ByteW-1:0]   key_byte_i,
  input  logic               cfg_we_i,
  input  logic               cfg_sel_i,
  input  logic [LaneW-1:0]   cfg_wdata_i,
  output logic [LaneW-1:0]   cfg_rdata_o,
  output logic [LaneW-1:0]   uuid_upper_o,
  output logic [LaneW-1:0]   uuid_lower_o
);

  logic [NLanes-1:0][LaneW-1:0] seed_q;
  logic [NLanes-1:0][LaneW-1:0] lane_q;
  logic [NLanes-1:0][LaneW-1:0] lane_fnv;
  logic [NLanes-1:0][LaneW-1:0] work_q;
  logic [NLanes-1:0][LaneW-1:0] acc_q;
  logic [NLanes-1:0][LaneW-1:0] prod_q;
  logic [NLanes-1:0][LaneW-1:0] mul_res;
  logic [LaneW-1:0]             fmix_c;
  logic [HalfW-1:0]             op_c;
  logic [NLanes-1:0][HalfW-1:0] op_w;
  logic [LaneW-1:0]             uuid_upper_q;
  logic [LaneW-1:0]             uuid_lower_q;

  assign fmix_c = cmd_i.const_sel ? FmixMulB : FmixMulA;

  // FNV-1a step: xor byte, multiply by 2^40 + 0x1b3
  always_comb begin
    logic [LaneW-1:0] x;
    logic [LaneW-1:0] low_prod;
    for (int i = 0; i < NLanes; i++) begin
      x           = lane_q[i] ^ {{(LaneW-ByteW){1'b0}}, key_byte_i};
      low_prod    = x * LaneW'(FnvLow);
      lane_fnv[i] = (x << FnvShift) + low_prod;
    end
  end

  // Select multiplier operands for the current partial product
  always_comb begin
    op_c = (cmd_i.phase == PH_LOHI) ? fmix_c[LaneW-1:HalfW] : fmix_c[HalfW-1:0];
    for (int i = 0; i < NLanes; i++) begin
      op_w[i]    = (cmd_i.phase == PH_HILO) ? work_q[i][LaneW-1:HalfW]
                                            : work_q[i][HalfW-1:0];
      mul_res[i] = LaneW'(op_w[i]) * LaneW'(op_c);
    end
  end

  // Seeds and lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q[LaneUpper] <= UpperSeedReset;
      seed_q[LaneLower] <= LowerSeedReset;
      lane_q[LaneUpper] <= UpperSeedReset;
      lane_q[LaneLower] <= LowerSeedReset;
    end else begin
      if (cfg_we_i) begin
        // a seed write also restarts its lane
        seed_q[cfg_sel_i] <= cfg_wdata_i;
        lane_q[cfg_sel_i] <= cfg_wdata_i;
      end else if (cmd_i.fin_load) begin
        lane_q <= seed_q;
      end else if (cmd_i.fnv_en) begin
        lane_q <= lane_fnv;
      end
    end
  end

  // Finalizer work, accumulator and product registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NLanes; i++) begin
      if (cmd_i.fin_load) begin
        work_q[i] <= lane_q[i] ^ (lane_q[i] >> FmixShift);
      end else if (cmd_i.xs_en) begin
        work_q[i] <= acc_q[i] ^ (acc_q[i] >> FmixShift);
      end
      if (cmd_i.mul_en) begin
        case (cmd_i.phase)
          PH_LOLO: begin
            prod_q[i] <= mul_res[i];
          end
          PH_LOHI: begin
            acc_q[i]  <= prod_q[i];
            prod_q[i] <= mul_res[i];
          end
          PH_HILO: begin
            acc_q[i]  <= acc_q[i] + {prod_q[i][HalfW-1:0], {HalfW{1'b0}}};
            prod_q[i] <= mul_res[i];
          end
          default: begin
            acc_q[i]  <= acc_q[i] + {prod_q[i][HalfW-1:0], {HalfW{1'b0}}};
          end
        endcase
      end
    end
  end

  // Capture UUID with version and variant marks
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      uuid_upper_q <= {work_q[LaneUpper][LaneW-1:16], VersionNibble,
                       work_q[LaneUpper][11:0]};
      uuid_lower_q <= {VariantBits, work_q[LaneLower][LaneW-3:0]};
    end
  end

  assign cfg_rdata_o  = seed_q[cfg_sel_i];
  assign uuid_upper_o = uuid_upper_q;
  assign uuid_lower_o = uuid_lower_q;

endmodule : dshu_dp

`default_nettype wire

[src/dual_seed_hash_uuid_v8.sv]
// Input: one non-final byte is taken per cycle while the input is not stalled;
//   the final byte stalls the input until its UUID enters the output register,
//   which waits until that register is free. The finalizer runs two rounds
//   of four phases on one 32x32 multiplier per lane.
// Reset: asynchronous, active low; seeds and lanes return to their defaults.
// ----------------------------------------------------------------------------
// dual_seed_hash_uuid_v8
// Top level: dual FNV-1a lanes with fmix64 finalizer producing a v8 UUID.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_seed_hash_uuid_v8
  import dshu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   key_byte_i,
  input  logic               final_byte_i,
  // UUID stream
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LaneW-1:0]   uuid_upper_o,
  output logic [LaneW-1:0]   uuid_lower_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [LaneW-1:0]   pwdata,
  output logic [LaneW-1:0]   prdata,
  output logic               pready
);

  dshu_cmd_t cmd;
  logic      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  dshu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .final_byte_i (final_byte_i),
    .in_stall_o   (in_stall_o),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  dshu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_byte_i   (key_byte_i),
    .cfg_we_i     (cfg_we),
    .cfg_sel_i    (paddr[3]),
    .cfg_wdata_i  (pwdata),
    .cfg_rdata_o  (prdata),
    .uuid_upper_o (uuid_upper_o),
    .uuid_lower_o (uuid_lower_o)
  );

endmodule : dual_seed_hash_uuid_v8

`default_nettype wire

[src/dshu_checker.sv]
// ----------------------------------------------------------------------------
// dshu_checker
// Port-level checks on the hash block's handshakes and sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module dshu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic final_byte_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic psel,
  input logic penable,
  input logic pready
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Close input after the last byte of a key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_byte_i |=> in_stall_o)
    else $error("input open during finalize");

  // Keep input open after an inner byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !final_byte_i |=> !in_stall_o)
    else $error("input closed after inner byte");

  // A new result only follows a finalize pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without finalize");

  // Complete every access at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("access not completed");

endmodule : dshu_checker

bind dual_seed_hash_uuid_v8 dshu_checker u_dshu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .final_byte_i (final_byte_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .psel         (psel),
  .penable      (penable),
  .pready       (pready)
);

`default_nettype wire
